// ===== rtl/divisor_count_sieve_first_table_macros.svh =====
// Assertion helpers
`ifndef DIVISOR_COUNT_SIEVE_FIRST_TABLE_MACROS_SVH
`define DIVISOR_COUNT_SIEVE_FIRST_TABLE_MACROS_SVH
`define DCS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/dcs_pkg.sv =====
package dcs_pkg;
	localparam logic [1:0] CMD_BUILD = 2'd0;
	localparam logic [1:0] CMD_FIRST = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;
	localparam logic [9:0] COUNT_SAT = 10'd1023;
	localparam logic [15:0] LIMIT_RESET = 16'd100;
	localparam int MAX_NUMBER = 65535;
	localparam int MAX_COUNT = 511;
endpackage

// ===== rtl/divisor_count_sieve_first_table.sv =====
// Divisor-count sieve. After reset the block clears both memories with s_axis_tready low. A
// build transaction (cmd 0) clears both tables again, sieves d(i) for i up to min(limit,
// MAX_NUMBER), scans for the first number of each count, then emits the record chain (kind 1,
// tlast on the final record; no output when the limit is zero). Lookups (cmd 1: first number
// of count K, cmd 2: d(i)) answer with one transaction: the result is presented after the
// synchronous reads of the count and first-number memories, and the next input is taken the
// cycle after the result leaves. A build clears both memories, sieves by read-modify-writes
// through the count memory port (about n*ln(n)/2 updates), scans every number for the
// first-number table, and per record scans the counts up to the highest count before one
// output, waiting while the receiver stalls.
// cmd 3 is dropped without output.
`include "divisor_count_sieve_first_table_macros.svh"
module divisor_count_sieve_first_table
	import dcs_pkg::*;
#(
	parameter int MAX_RECORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [1:0] cmd, [17:2] operand, rest zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [8:0] divisor_count, [24:9] number, rest zero
	output logic        m_axis_tuser,   // result_kind
	output logic        m_axis_tlast    // is_last
);
	localparam int NW = $clog2(MAX_NUMBER + 1);
	localparam int KW = $clog2(MAX_COUNT + 1);
	localparam int RW = $clog2(MAX_RECORDS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOK_RD, ST_LOOK_RD2, ST_LOOK_OUT, ST_CLR, ST_SV_RD, ST_SV_WR,
		ST_SC_RD, ST_SC_WR, ST_EM_RD, ST_EM_CHK, ST_OUT
	} state_t;

	logic [9:0]  cnt_mem [0:MAX_NUMBER];
	logic [15:0] fst_mem [0:MAX_COUNT];

	state_t      state_q;
	logic [15:0] limit_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] j_q, k_q, addr_q;   // sieve: j, k, product j*k
	logic [NW:0] i_q;                  // clear / scan index
	logic [1:0]  cmd_q;
	logic [15:0] op_q;
	logic [9:0]  cnt_rd;
	logic [15:0] fst_rd;
	logic [KW-1:0] hi_q, prev_k_q, best_k_q, kscan_q;
	logic [15:0] prev_v_q, best_v_q;
	logic [RW-1:0] nrec_q;
	logic        pend_q;               // emit scan: the first-table read at kscan_q is pending for its check
	logic [8:0]  o_cnt_q;
	logic [15:0] o_num_q;
	logic        o_kind_q, o_last_q, o_valid_q;

	// scan needs count then first; keep count in a register for the write step
	logic [9:0] c_s2;
	logic       chk_q;  // scan: first-table read for c_s2 valid this cycle
	logic       scan_wr;

	// memory port control
	logic          cw_en, fw_en;
	logic [NW-1:0] cr_addr, cw_addr;
	logic [9:0]    cw_data;
	logic [KW-1:0] fr_addr, fw_addr;
	logic [15:0]   fw_data;

	always_ff @(posedge clk) begin
		if (cw_en)
			cnt_mem[cw_addr] <= cw_data;
		cnt_rd <= cnt_mem[cr_addr];
		if (fw_en)
			fst_mem[fw_addr] <= fw_data;
		fst_rd <= fst_mem[fr_addr];
	end

	logic [NW:0] prod;        // j*(k+1) next product
	logic [NW:0] j_inc;       // j+1
	logic [NW+1:0] jj_next;   // (j+1)^2
	logic [10:0] sum_c;
	logic [9:0]  sat_c;
	logic        sv_diag;
	assign sv_diag = (k_q == j_q);
	assign sum_c = {1'b0, cnt_rd} + (sv_diag ? 11'd1 : 11'd2);
	assign sat_c = (sum_c > {1'b0, COUNT_SAT}) ? COUNT_SAT : sum_c[9:0];
	assign prod = {1'b0, addr_q} + {1'b0, j_q};
	assign j_inc = {1'b0, j_q} + 1'b1;
	assign jj_next = {1'b0, j_inc} * {1'b0, j_inc};

	logic [15:0] clamp_lim;
	assign clamp_lim = ({16'b0, limit_q} > 32'(MAX_NUMBER)) ? 16'(MAX_NUMBER) : limit_q;

	assign scan_wr = chk_q && (c_s2 < COUNT_SAT) && (c_s2 <= 10'(MAX_COUNT)) && (fst_rd == 0);

	always_comb begin
		cw_en = 1'b0; cw_addr = addr_q; cw_data = sat_c;
		cr_addr = addr_q;
		fw_en = 1'b0; fw_addr = kscan_q; fw_data = '0;
		fr_addr = kscan_q;
		case (state_q)
			ST_IDLE: begin
				cr_addr = s_axis_tdata[2 +: NW];
				fr_addr = s_axis_tdata[2 +: KW];
			end
			ST_LOOK_RD: begin
				// hold the count read; fetch first number by operand or by count
				cr_addr = op_q[NW-1:0];
				if (cmd_q == CMD_FIRST)
					fr_addr = op_q[KW-1:0];
				else
					fr_addr = (cnt_rd > 10'(MAX_COUNT)) ? '0 : cnt_rd[KW-1:0];
			end
			ST_CLR: begin
				cw_en = 1'b1; cw_addr = i_q[NW-1:0]; cw_data = '0;
				fw_en = (i_q <= (NW+1)'(MAX_COUNT)); fw_addr = i_q[KW-1:0];
			end
			ST_SV_WR: cw_en = 1'b1;
			ST_SC_RD: cr_addr = i_q[NW-1:0];
			ST_SC_WR: begin
				fr_addr = cnt_rd[KW-1:0];
			end
			ST_EM_RD: begin
				// scan write: first_table[c] = i when still empty
				fw_en = scan_wr; fw_addr = c_s2[KW-1:0]; fw_data = i_q[15:0];
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !o_valid_q;
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata = {7'b0, o_num_q, o_cnt_q};
	assign m_axis_tuser = o_kind_q;
	assign m_axis_tlast = o_last_q;

	// output register loads a new transaction this cycle
	logic out_load;
	assign out_load = (state_q == ST_LOOK_RD2) ||
		((state_q == ST_OUT) && (!o_valid_q || m_axis_tready) && (best_v_q != 0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR; limit_q <= LIMIT_RESET; o_valid_q <= 1'b0; n_q <= '0;
			i_q <= '0; hi_q <= '0; chk_q <= 1'b0; pend_q <= 1'b0; nrec_q <= '0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (o_valid_q && m_axis_tready && !out_load)
				o_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					cmd_q <= s_axis_tdata[1:0];
					op_q <= s_axis_tdata[17:2];
					if (s_axis_tdata[1:0] == CMD_BUILD) begin
						state_q <= ST_CLR; i_q <= '0;
						n_q <= clamp_lim[NW-1:0];
					end else if (s_axis_tdata[1:0] == CMD_FIRST ||
						s_axis_tdata[1:0] == CMD_COUNT)
						state_q <= ST_LOOK_RD;
				end
				ST_LOOK_RD: state_q <= ST_LOOK_RD2;
				ST_LOOK_RD2: begin
					state_q <= ST_IDLE; o_valid_q <= 1'b1;
					o_kind_q <= 1'b0; o_last_q <= 1'b1;
					if (cmd_q == CMD_FIRST) begin
						if ({16'b0, op_q} > 32'(MAX_COUNT)) begin
							o_cnt_q <= '0; o_num_q <= '0;
						end else begin
							o_cnt_q <= op_q[8:0]; o_num_q <= fst_rd;
						end
					end else if ({16'b0, op_q} > 32'(MAX_NUMBER)) begin
						o_cnt_q <= '0; o_num_q <= '0;
					end else begin
						o_cnt_q <= cnt_rd[8:0];
						o_num_q <= (cnt_rd > 10'(MAX_COUNT)) ? 16'd0 : fst_rd;
					end
				end
				ST_CLR: begin
					i_q <= i_q + 1'b1;
					if (i_q == (NW+1)'(MAX_NUMBER)) begin
						hi_q <= '0;
						j_q <= (NW)'(1); k_q <= (NW)'(1); addr_q <= (NW)'(1);
						state_q <= (n_q == 0) ? ST_IDLE : ST_SV_RD;
					end
				end
				ST_SV_RD: state_q <= ST_SV_WR;
				ST_SV_WR: begin
					// advance k; when j*(k+1) > n, next j with (j+1)^2
					if (prod <= {1'b0, n_q}) begin
						k_q <= k_q + 1'b1; addr_q <= prod[NW-1:0]; state_q <= ST_SV_RD;
					end else if (jj_next <= {2'b0, n_q}) begin
						j_q <= j_q + 1'b1; k_q <= j_q + 1'b1;
						addr_q <= jj_next[NW-1:0]; state_q <= ST_SV_RD;
					end else begin
						i_q <= (NW+1)'(1); chk_q <= 1'b0; state_q <= ST_SC_RD;
					end
				end
				ST_SC_RD: begin
					chk_q <= 1'b0;
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					c_s2 <= cnt_rd; chk_q <= 1'b1; kscan_q <= cnt_rd[KW-1:0];
					state_q <= ST_EM_RD; // transient: check step
				end
				ST_EM_RD: begin
					if (chk_q) begin
						chk_q <= 1'b0;
						if (scan_wr) begin
							if (c_s2[KW-1:0] > hi_q) hi_q <= c_s2[KW-1:0];
						end
						if (i_q == {1'b0, n_q}) begin
							prev_k_q <= '0; prev_v_q <= '0; nrec_q <= '0;
							kscan_q <= (KW)'(1); best_v_q <= '0; best_k_q <= '0;
							state_q <= ST_EM_CHK; pend_q <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1; state_q <= ST_SC_RD;
						end
					end
				end
				ST_EM_CHK: begin
					// each count: read issued at kscan_q, checked once pend_q is set
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (fst_rd > prev_v_q && (best_v_q == 0 || fst_rd <= best_v_q)
							&& kscan_q > prev_k_q && kscan_q <= hi_q) begin
							best_v_q <= fst_rd; best_k_q <= kscan_q;
						end
						if (kscan_q >= hi_q || {1'b0, kscan_q} == (KW+1)'(MAX_COUNT))
							state_q <= ST_OUT;
						else
							kscan_q <= kscan_q + 1'b1;
					end
				end
				ST_OUT: if (!o_valid_q || m_axis_tready) begin
					if (best_v_q == 0) begin
						state_q <= ST_IDLE;
					end else begin
						o_valid_q <= 1'b1; o_kind_q <= 1'b1;
						o_cnt_q <= 9'(best_k_q); o_num_q <= best_v_q;
						o_last_q <= (nrec_q == RW'(MAX_RECORDS - 1)) || (best_k_q >= hi_q);
						nrec_q <= nrec_q + 1'b1;
						prev_k_q <= best_k_q; prev_v_q <= best_v_q;
						best_v_q <= '0;
						kscan_q <= best_k_q + 1'b1;
						state_q <= ((nrec_q == RW'(MAX_RECORDS - 1)) || (best_k_q >= hi_q))
							? ST_IDLE : ST_EM_CHK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DCS_ASSERT_IMPL(a_ready_idle, s_axis_tready, state_q == ST_IDLE, "ready outside idle")
	`DCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
		"result dropped")
	`DCS_ASSERT_IMPL(a_look_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast,
		"lookup without last")
endmodule

// ===== test/tb_divisor_count_sieve_first_table.sv =====
module tb_divisor_count_sieve_first_table;
	import dcs_pkg::*;

	localparam int NUM_TOP = 65535;
	localparam int COUNT_TOP = 511;
	localparam int RECORD_CAP = 64;
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_RECORD = 1'b1;
	localparam int STALL_LIMIT = 4000000;

	typedef struct packed {
		logic       kind;
		logic [8:0] cnt;
		logic [15:0] num;
		logic       last;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [1:0] cmd, [17:2] operand
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [8:0] divisor_count, [24:9] number
	logic        m_axis_tuser;   // result_kind
	logic        m_axis_tlast;   // is_last

	// Predictor state: sieved counts, first number per count, configured limit.
	logic [9:0]  div_count [0:NUM_TOP];
	logic [15:0] first_num [0:COUNT_TOP];
	int          top_count;
	logic [15:0] limit_reg;

	answer_t pending_answers[$];
	int mismatches;
	int builds_sent, lookups_sent, records_seen, answers_seen;
	bit idle_on;
	int hold_len;

	divisor_count_sieve_first_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Saturating add into the count store.
	function automatic void bump(int idx, int amount);
		int v;
		v = div_count[idx] + amount;
		if (v > COUNT_SAT) v = COUNT_SAT;
		div_count[idx] = v[9:0];
	endfunction

	// Sieve d(i), fill the first-number table and queue the record chain.
	function automatic void predict_build();
		int n, j, k, c, prev_k, prev_v, best_k, best_v, emitted;
		answer_t a;
		n = limit_reg;
		for (int i = 0; i <= NUM_TOP; i++) div_count[i] = '0;
		for (int i = 0; i <= COUNT_TOP; i++) first_num[i] = '0;
		top_count = 0;
		for (j = 1; j * j <= n; j++) begin
			bump(j * j, 1);
			for (k = j + 1; k <= n / j; k++) bump(j * k, 2);
		end
		for (int i = 1; i <= n; i++) begin
			c = div_count[i];
			if (c < COUNT_SAT && c <= COUNT_TOP && first_num[c] == 0) first_num[c] = i[15:0];
		end
		for (int i = COUNT_TOP; i > 0; i--) begin
			if (first_num[i] != 0) begin
				top_count = i;
				break;
			end
		end
		prev_k = 0;
		prev_v = 0;
		emitted = 0;
		while (emitted < RECORD_CAP) begin
			best_k = 0;
			best_v = 0;
			for (int i = prev_k + 1; i <= top_count; i++) begin
				if (first_num[i] > prev_v && (best_v == 0 || first_num[i] <= best_v)) begin
					best_v = first_num[i];
					best_k = i;
				end
			end
			if (best_v == 0) break;
			a.kind = KIND_RECORD;
			a.cnt = best_k[8:0];
			a.num = best_v[15:0];
			a.last = 1'b0;
			pending_answers.push_back(a);
			emitted++;
			prev_k = best_k;
			prev_v = best_v;
		end
		// Mark the final record of this build.
		if (emitted > 0) pending_answers[pending_answers.size() - 1].last = 1'b1;
	endfunction

	function automatic void predict_item(logic [1:0] cmd, logic [15:0] op);
		answer_t a;
		int c;
		a.kind = KIND_LOOKUP;
		a.last = 1'b1;
		case (cmd)
			CMD_BUILD: begin
				predict_build();
				return;
			end
			CMD_FIRST: begin
				if (op > COUNT_TOP) begin
					a.cnt = '0;
					a.num = '0;
				end else begin
					a.cnt = op[8:0];
					a.num = first_num[op];
				end
			end
			CMD_COUNT: begin
				c = div_count[op];
				a.cnt = c[8:0];
				a.num = (c <= COUNT_TOP) ? first_num[c] : 16'd0;
			end
			default: return;  // undefined command: dropped
		endcase
		pending_answers.push_back(a);
	endfunction

	// Offer one transaction, with an optional idle burst in front of it.
	task automatic send_item(logic [1:0] cmd, logic [15:0] op);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, op, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(cmd, op);
		if (cmd == CMD_BUILD) builds_sent++;
		else if (cmd != CMD_UNDEF) lookups_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// Write the limit while the block is idle.
	task automatic write_limit(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	// A trailing lookup proves the block finished even an empty build.
	task automatic build_and_settle();
		send_item(CMD_BUILD, 16'($urandom));
		send_item(CMD_FIRST, 16'd1);
		drain();
	endtask

	task automatic test_lookup_before_build();
		send_item(CMD_FIRST, 16'd0);
		send_item(CMD_FIRST, 16'd511);
		send_item(CMD_FIRST, 16'd512);
		send_item(CMD_FIRST, 16'hFFFF);
		send_item(CMD_COUNT, 16'd0);
		send_item(CMD_COUNT, 16'd1);
		send_item(CMD_COUNT, 16'hFFFF);
		send_item(CMD_UNDEF, 16'hFFFF);
		send_item(CMD_UNDEF, 16'd0);
		drain();
	endtask

	task automatic test_default_build();
		build_and_settle();
		send_item(CMD_COUNT, 16'd1);
		send_item(CMD_COUNT, 16'd60);
		send_item(CMD_COUNT, 16'd97);
		send_item(CMD_COUNT, 16'd100);
		send_item(CMD_COUNT, 16'd101);
		send_item(CMD_FIRST, 16'd12);
		send_item(CMD_FIRST, 16'd13);
		drain();
	endtask

	// Limit zero emits nothing; limit one gives a single record.
	task automatic test_limit_edges();
		write_limit(16'd0);
		build_and_settle();
		send_item(CMD_COUNT, 16'd1);
		drain();
		write_limit(16'd1);
		build_and_settle();
		send_item(CMD_COUNT, 16'd1);
		send_item(CMD_COUNT, 16'd2);
		drain();
	endtask

	task automatic send_random_lookup(int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) send_item(CMD_UNDEF, 16'($urandom));
		else if (r < 60) send_item(CMD_COUNT, 16'($urandom_range(0, lim + 2)));
		else if (r < 70) send_item(CMD_COUNT, 16'($urandom));
		else if (r < 92) send_item(CMD_FIRST, 16'($urandom_range(0, 40)));
		else send_item(CMD_FIRST, 16'($urandom));
	endtask

	task automatic test_random_lookups();
		int lim;
		lim = $urandom_range(200, 3000);
		write_limit(lim[15:0]);
		build_and_settle();
		for (int i = 0; i < 240; i++) send_random_lookup(lim);
		drain();
	endtask

	// Hold the receiver off while lookups keep coming so the block backs up.
	task automatic test_backpressure();
		hold_len = 400;
		for (int i = 0; i < 30; i++) send_item(CMD_COUNT, 16'($urandom_range(0, 300)));
		drain();
	endtask

	task automatic test_full_limit();
		write_limit(16'hFFFF);
		build_and_settle();
		idle_on = 1'b0;
		for (int i = 0; i < 40; i++) send_random_lookup(NUM_TOP);
		drain();
	endtask

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.cnt = m_axis_tdata[8:0];
			got.num = m_axis_tdata[24:9];
			got.last = m_axis_tlast;
			if (got.kind == KIND_RECORD) records_seen++;
			else answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d cnt=%0d num=%0d last=%0d",
						got.kind, got.cnt, got.num, got.last);
			end else begin
				want = pending_answers.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp kind=%0d cnt=%0d num=%0d last=%0d, got %0d %0d %0d %0d",
							want.kind, want.cnt, want.num, want.last,
							got.kind, got.cnt, got.num, got.last);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	int quiet_cycles;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL divisor_count_sieve_first_table");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		idle_on = 1'b1;
		hold_len = 0;
		quiet_cycles = 0;
		mismatches = 0;
		builds_sent = 0;
		lookups_sent = 0;
		records_seen = 0;
		answers_seen = 0;
		limit_reg = LIMIT_RESET;
		for (int i = 0; i <= NUM_TOP; i++) div_count[i] = '0;
		for (int i = 0; i <= COUNT_TOP; i++) first_num[i] = '0;
		top_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lookup_before_build();
		test_default_build();
		test_limit_edges();
		test_random_lookups();
		test_backpressure();
		test_full_limit();

		repeat (20) @(posedge clk);
		$display("covered %0d builds (limits 0, 1, 100, random, 65535), %0d lookups",
			builds_sent, lookups_sent);
		$display("checked %0d record and %0d lookup results, %0d mismatches",
			records_seen, answers_seen, mismatches);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("PASS divisor_count_sieve_first_table");
		end else begin
			$display("FAIL divisor_count_sieve_first_table");
		end
		$finish;
	end
endmodule
